// File: src/wipr_pkg.sv
// Shared types, constants and helper functions for the WAV impulse-response parser.
// Used by every module of the block except the input queue; depends on nothing else.
package wipr_pkg;

    // Chunk tags, little-endian as they arrive in the file.
    localparam logic [31:0] TAG_FMT  = 32'h20746D66;
    localparam logic [31:0] TAG_DATA = 32'h61746164;

    // Shortest file that counts as complete.
    localparam logic [5:0] MIN_FILE = 6'd44;

    // Default tap capacity.
    localparam int DEF_MAX_TAPS = 8192;

    // Default expected sample rate.
    localparam logic [31:0] DEF_RATE = 32'd48000;

    // Status codes.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HEADER = 3'd1;
    localparam logic [2:0] ST_NODATA = 3'd2;
    localparam logic [2:0] ST_FORMAT = 3'd3;
    localparam logic [2:0] ST_WIDTH  = 3'd4;
    localparam logic [2:0] ST_SHORT  = 3'd5;

    // Sample conversion modes.
    localparam logic [1:0] MODE_FLOAT = 2'd0;
    localparam logic [1:0] MODE_PCM16 = 2'd1;
    localparam logic [1:0] MODE_PCM32 = 2'd2;

    // Configuration register indexes.
    localparam logic REG_RATE = 1'b0;
    localparam logic REG_TAPS = 1'b1;

    // One result on its way from the parser to the converter.
    typedef struct packed {
        logic        valid;
        logic [1:0]  mode;
        logic [31:0] raw;
        logic [12:0] index;
        logic        fin;
        logic [2:0]  status;
        logic [13:0] count;
    } t_res;

    // Request to the iterative divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [12:0] divisor;
    } t_div_req;

    // Answer of the iterative divider.
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    // Expected byte of the RIFF/WAVE header at a given offset.
    function automatic logic [7:0] head_byte(input logic [3:0] off);
        logic [7:0] v;
        unique case (off)
            4'd0:    v = 8'h52;
            4'd1:    v = 8'h49;
            4'd2:    v = 8'h46;
            4'd3:    v = 8'h46;
            4'd8:    v = 8'h57;
            4'd9:    v = 8'h41;
            4'd10:   v = 8'h56;
            4'd11:   v = 8'h45;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Leading-zero count of a 32-bit word (32 when the word is zero).
    function automatic logic [5:0] lzc32(input logic [31:0] w);
        logic [5:0] n;
        logic       found;
        n = 6'd32;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found && w[i]) begin
                n = 6'(31 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Replace one byte lane of a word, clearing the rest first if asked.
    function automatic logic [31:0] put_lane(input logic [31:0] w, input logic [1:0] sel,
                                             input logic [7:0] b, input logic clr);
        logic [31:0] v;
        v = clr ? 32'd0 : w;
        v[{sel, 3'b000} +: 8] = b;
        return v;
    endfunction

endpackage

// File: src/wav_impulse_response_parser.sv
// WAV impulse-response parser: one file byte per beat in, samples and a final status out.
// An input byte passes the input queue, stage one, stage two and the output register.
// Throughput: one byte per cycle unless the output stalls; a data chunk whose sample is
// not 1, 2 or 4 bytes wide stalls input while the iterative divider counts the samples.
// Reset (synchronous, active low) clears the parse state and sets expected_rate to 48000
// and max_taps to 8192; the input queue is empty and accepts bytes once reset is released.
module wav_impulse_response_parser #(
    parameter int MAX_TAPS = wipr_pkg::DEF_MAX_TAPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_sample_valid,
    output logic [31:0] o_sample_word,
    output logic [12:0] o_sample_index,
    output logic        o_finished,
    output logic [2:0]  o_status,
    output logic [13:0] o_tap_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wipr_pkg::*;

    logic [31:0] r_exp_rate;
    logic [13:0] r_max_taps;
    logic        q_valid;
    logic [7:0]  q_byte;
    logic        q_eof;
    logic        q_pop;
    logic        c_free;
    logic        p_valid;
    t_res        p_res;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    // Configuration registers.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TAPS) ? {18'd0, r_max_taps} : r_exp_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_rate <= DEF_RATE;
            r_max_taps <= 14'(DEF_MAX_TAPS);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_RATE) r_exp_rate <= pwdata;
            else                      r_max_taps <= pwdata[13:0];
        end
    end

    // Front: input queue.
    wipr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_byte  (i_file_byte),
        .i_eof   (i_end_of_file),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_byte  (q_byte),
        .o_eof   (q_eof)
    );

    // Back: chunk parser.
    wipr_parse #(.MAX_TAPS(MAX_TAPS)) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_byte      (q_byte),
        .i_eof       (q_eof),
        .o_pop       (q_pop),
        .i_free      (c_free),
        .o_res_valid (p_valid),
        .o_res       (p_res),
        .i_exp_rate  (r_exp_rate),
        .i_max_taps  (r_max_taps),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    // Sample-count divider.
    wipr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sample conversion and output register.
    wipr_conv u_conv (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (p_valid),
        .i_res          (p_res),
        .o_free         (c_free),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_valid (o_sample_valid),
        .o_sample_word  (o_sample_word),
        .o_sample_index (o_sample_index),
        .o_finished     (o_finished),
        .o_status       (o_status),
        .o_tap_count    (o_tap_count)
    );
endmodule

// File: src/wipr_fifo.sv
// Input queue of the WAV parser: two-entry buffer of file bytes and end marks.
// Depends on nothing but the clock and reset.
module wipr_fifo (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_eof,
    output logic       o_valid,
    input  logic       i_pop,
    output logic [7:0] o_byte,
    output logic       o_eof
);
    logic [8:0] r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_byte  = r_mem[r_rp][7:0];
    assign o_eof   = r_mem[r_rp][8];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= {i_eof, i_byte};
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end
endmodule

// File: src/wipr_div.sv
// Iterative restoring divider for the WAV parser: one quotient bit per cycle.
// Uses the request and answer types of wipr_pkg.
module wipr_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wipr_pkg::t_div_req i_req,
    output wipr_pkg::t_div_rsp o_rsp
);
    import wipr_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [12:0] r_rem;
    logic [12:0] r_dvs;
    logic [13:0] trial;
    logic        ge;

    assign trial = {r_rem, r_quo[31]};
    assign ge    = (trial >= {1'b0, r_dvs});

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    // Datapath: quotient bits shift in where dividend bits shift out.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? 13'(trial - {1'b0, r_dvs}) : trial[12:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    // Control: 32 steps, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= 5'(r_cnt + 5'd1);
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: src/wipr_parse.sv
// Chunk parser of the WAV parser: walks RIFF chunks byte by byte and emits results.
// Uses wipr_pkg; the divider answers the sample-count division.
module wipr_parse #(
    parameter int MAX_TAPS = wipr_pkg::DEF_MAX_TAPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_eof,
    output logic               o_pop,
    input  logic               i_free,
    output logic               o_res_valid,
    output wipr_pkg::t_res     o_res,
    input  logic [31:0]        i_exp_rate,
    input  logic [13:0]        i_max_taps,
    output wipr_pkg::t_div_req o_div_req,
    input  wipr_pkg::t_div_rsp i_div_rsp
);
    import wipr_pkg::*;

    // Parse phases.
    localparam logic [2:0] PH_HEAD = 3'd0;
    localparam logic [2:0] PH_CHDR = 3'd1;
    localparam logic [2:0] PH_FMT  = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_HOLD = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    // Cap limit that fits the 14-bit count.
    localparam int          CAP_INT = (MAX_TAPS > 16383) ? 16383 : MAX_TAPS;
    localparam logic [13:0] CAP_LIM = 14'(CAP_INT);

    logic [2:0]  r_phase, n_phase;
    logic [12:0] r_off, n_off;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_asm, n_asm;
    logic [13:0] r_emit, n_emit;
    logic [13:0] r_target, n_target;
    logic [5:0]  r_total, n_total;
    logic [32:0] r_skip, n_skip;
    logic [2:0]  r_held, n_held;
    logic        r_div_go;
    logic        r_div_ready;

    logic [12:0] bps;
    logic [31:0] len_new;
    logic        is_disp;
    logic        fmt_ok;
    logic        fast;
    logic        need_div;
    logic        stall;
    logic        consume;
    logic [13:0] cap;
    logic [31:0] quo;
    logic [13:0] tgt;
    logic        fin_f;
    logic [2:0]  fin_st;
    logic        fail_f;
    logic [2:0]  fail_st;
    logic [12:0] off_inc;
    logic [31:0] asm_new;
    logic [13:0] emit_inc;
    logic [32:0] skip_dec;
    logic [32:0] skip_amt;
    t_res        res;

    // Effective cap: max_taps clamped to one and the tap capacity.
    always_comb begin
        cap = i_max_taps;
        if (cap == 14'd0) cap = 14'd1;
        if (cap > CAP_LIM) cap = CAP_LIM;
    end

    // Dispatch of a data chunk and the division it may need.
    assign bps      = r_bits[15:3];
    assign len_new  = {i_byte, r_len[23:0]};
    assign is_disp  = (r_phase == PH_CHDR) && (r_off == 13'd7);
    assign fmt_ok   = (r_chan == 16'd1) && (r_rate == i_exp_rate) &&
                      ((r_fmt == 16'd1) || (r_fmt == 16'd3));
    assign fast     = (bps == 13'd1) || (bps == 13'd2) || (bps == 13'd4);
    assign need_div = is_disp && (r_tag == TAG_DATA) && fmt_ok && (bps != 13'd0) && !fast;
    assign stall    = need_div && !r_div_ready;
    assign consume  = i_valid && i_free && !stall;
    assign o_pop    = consume;

    assign o_div_req.start    = i_valid && stall && !r_div_go;
    assign o_div_req.dividend = len_new;
    assign o_div_req.divisor  = bps;

    // Number of whole samples in the data chunk, capped.
    always_comb begin
        if (bps == 13'd1)      quo = len_new;
        else if (bps == 13'd2) quo = {1'b0, len_new[31:1]};
        else if (bps == 13'd4) quo = {2'b0, len_new[31:2]};
        else                   quo = i_div_rsp.quotient;
        tgt = (quo > {18'd0, cap}) ? cap : quo[13:0];
    end

    // Next state for one consumed byte.
    always_comb begin
        n_phase  = r_phase;
        n_off    = r_off;
        n_tag    = r_tag;
        n_len    = r_len;
        n_fmt    = r_fmt;
        n_chan   = r_chan;
        n_rate   = r_rate;
        n_bits   = r_bits;
        n_asm    = r_asm;
        n_emit   = r_emit;
        n_target = r_target;
        n_skip   = r_skip;
        n_held   = r_held;
        res      = '0;
        fin_f    = 1'b0;
        fin_st   = ST_OK;
        fail_f   = 1'b0;
        fail_st  = ST_OK;
        n_total  = (r_total < MIN_FILE) ? 6'(r_total + 6'd1) : r_total;
        off_inc  = 13'(r_off + 13'd1);
        asm_new  = r_asm;
        emit_inc = 14'(r_emit + 14'd1);
        skip_dec = (r_skip != 33'd0) ? 33'(r_skip - 33'd1) : r_skip;
        skip_amt = {1'b0, r_len} + {32'd0, r_len[0]};

        unique case (r_phase)
            // Fixed RIFF/WAVE header.
            PH_HEAD: begin
                if (r_off < 13'd12 && (r_off < 13'd4 || r_off >= 13'd8) &&
                    i_byte != head_byte(r_off[3:0])) begin
                    fail_f  = 1'b1;
                    fail_st = ST_HEADER;
                end else if (off_inc >= 13'd12) begin
                    n_off   = '0;
                    n_phase = PH_CHDR;
                end else begin
                    n_off = off_inc;
                end
            end
            // Chunk tag and length, then dispatch.
            PH_CHDR: begin
                if (r_off < 13'd4) begin
                    n_tag = put_lane(r_tag, r_off[1:0], i_byte, r_off == 13'd0);
                end else begin
                    n_len = put_lane(r_len, r_off[1:0], i_byte, r_off == 13'd4);
                end
                n_off = off_inc;
                if (off_inc >= 13'd8) begin
                    n_off = '0;
                    if (r_tag == TAG_FMT) begin
                        if (len_new < 32'd16) begin
                            fail_f  = 1'b1;
                            fail_st = ST_FORMAT;
                        end else begin
                            n_phase = PH_FMT;
                        end
                    end else if (r_tag == TAG_DATA) begin
                        if (!fmt_ok) begin
                            fail_f  = 1'b1;
                            fail_st = ST_FORMAT;
                        end else if (bps == 13'd0) begin
                            fail_f  = 1'b1;
                            fail_st = ST_WIDTH;
                        end else begin
                            n_target = tgt;
                            n_emit   = '0;
                            n_asm    = '0;
                            n_phase  = PH_DATA;
                            if (tgt == 14'd0) begin
                                fin_f  = 1'b1;
                                fin_st = ST_OK;
                            end
                        end
                    end else begin
                        n_skip  = {1'b0, len_new} + {32'd0, len_new[0]};
                        n_phase = ({1'b0, len_new} + {32'd0, len_new[0]} == 33'd0) ?
                                  PH_CHDR : PH_SKIP;
                    end
                end
            end
            // Format chunk fields.
            PH_FMT: begin
                if (r_off < 13'd2) begin
                    n_fmt = 16'(put_lane({16'd0, r_fmt}, r_off[1:0], i_byte, r_off == 13'd0));
                end else if (r_off < 13'd4) begin
                    n_chan = 16'(put_lane({16'd0, r_chan}, {1'b0, r_off[0]}, i_byte,
                                          r_off == 13'd2));
                end else if (r_off < 13'd8) begin
                    n_rate = put_lane(r_rate, r_off[1:0], i_byte, r_off == 13'd4);
                end else if (r_off == 13'd14 || r_off == 13'd15) begin
                    n_bits = 16'(put_lane({16'd0, r_bits}, {1'b0, r_off[0]}, i_byte,
                                          r_off == 13'd14));
                end
                n_off = off_inc;
                if (off_inc >= 13'd16) begin
                    n_off   = '0;
                    n_skip  = 33'(skip_amt - 33'd16);
                    n_phase = (33'(skip_amt - 33'd16) == 33'd0) ? PH_CHDR : PH_SKIP;
                end
            end
            // Unknown chunk body and padding.
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 33'd0) begin
                    n_off   = '0;
                    n_phase = PH_CHDR;
                end
            end
            // Sample bytes.
            PH_DATA: begin
                if (r_off < 13'd4) begin
                    asm_new = put_lane(r_asm, r_off[1:0], i_byte, 1'b0);
                end
                n_asm = asm_new;
                n_off = off_inc;
                if (off_inc >= bps) begin
                    n_off = '0;
                    n_asm = '0;
                    if (r_fmt == 16'd3 && r_bits == 16'd32) begin
                        res.mode = MODE_FLOAT;
                    end else if (r_fmt == 16'd1 && r_bits == 16'd16) begin
                        res.mode = MODE_PCM16;
                    end else if (r_fmt == 16'd1 && r_bits == 16'd32) begin
                        res.mode = MODE_PCM32;
                    end else begin
                        fail_f  = 1'b1;
                        fail_st = ST_WIDTH;
                    end
                    if (!fail_f) begin
                        res.valid = 1'b1;
                        res.raw   = asm_new;
                        res.index = r_emit[12:0];
                        n_emit    = emit_inc;
                        if (emit_inc >= r_target) begin
                            fin_f  = 1'b1;
                            fin_st = ST_OK;
                        end
                    end
                end
            end
            // Error found early, reported once the file is long enough.
            PH_HOLD: begin
                if (n_total >= MIN_FILE) begin
                    fin_f  = 1'b1;
                    fin_st = r_held;
                end
            end
            default: begin
            end
        endcase

        // An error finishes at once or waits for the minimum length.
        if (fail_f) begin
            if (n_total >= MIN_FILE) begin
                fin_f  = 1'b1;
                fin_st = fail_st;
            end else begin
                n_held  = fail_st;
                n_phase = PH_HOLD;
            end
        end

        // End of file closes any open parse.
        if (i_eof && !fin_f && n_phase <= PH_HOLD) begin
            fin_f = 1'b1;
            if (n_total < MIN_FILE)       fin_st = ST_SHORT;
            else if (n_phase == PH_HOLD)  fin_st = n_held;
            else if (n_phase == PH_DATA)  fin_st = ST_OK;
            else                          fin_st = ST_NODATA;
        end

        if (fin_f) begin
            res.fin    = 1'b1;
            res.status = fin_st;
            res.count  = (fin_st == ST_OK) ? n_target : 14'd0;
            n_phase    = PH_DONE;
        end

        // Every end of file starts a fresh parse.
        if (i_eof) begin
            n_phase  = PH_HEAD;
            n_off    = '0;
            n_tag    = '0;
            n_len    = '0;
            n_fmt    = '0;
            n_chan   = '0;
            n_rate   = '0;
            n_bits   = '0;
            n_asm    = '0;
            n_emit   = '0;
            n_target = '0;
            n_total  = '0;
            n_skip   = '0;
            n_held   = ST_OK;
        end
    end

    assign o_res       = res;
    assign o_res_valid = consume && (res.valid || res.fin);

    // Parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEAD;
            r_off    <= '0;
            r_tag    <= '0;
            r_len    <= '0;
            r_fmt    <= '0;
            r_chan   <= '0;
            r_rate   <= '0;
            r_bits   <= '0;
            r_asm    <= '0;
            r_emit   <= '0;
            r_target <= '0;
            r_total  <= '0;
            r_skip   <= '0;
            r_held   <= ST_OK;
        end else if (consume) begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_tag    <= n_tag;
            r_len    <= n_len;
            r_fmt    <= n_fmt;
            r_chan   <= n_chan;
            r_rate   <= n_rate;
            r_bits   <= n_bits;
            r_asm    <= n_asm;
            r_emit   <= n_emit;
            r_target <= n_target;
            r_total  <= n_total;
            r_skip   <= n_skip;
            r_held   <= n_held;
        end
    end

    // Divider handshake: launched once per dispatch, answer kept until used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go    <= 1'b0;
            r_div_ready <= 1'b0;
        end else if (consume) begin
            r_div_go    <= 1'b0;
            r_div_ready <= 1'b0;
        end else begin
            if (o_div_req.start) r_div_go <= 1'b1;
            if (i_div_rsp.done)  r_div_ready <= 1'b1;
        end
    end
endmodule

// File: src/wipr_conv.sv
// Sample converter of the WAV parser: PCM or float samples to single-precision bits.
// Three-stage pipeline with the output register; uses the result type of wipr_pkg.
module wipr_conv (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  wipr_pkg::t_res i_res,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_sample_valid,
    output logic [31:0]    o_sample_word,
    output logic [12:0]    o_sample_index,
    output logic           o_finished,
    output logic [2:0]     o_status,
    output logic [13:0]    o_tap_count
);
    import wipr_pkg::*;

    logic        r_s1v;
    t_res        r_s1;
    logic        r_s2v;
    t_res        r_s2;
    logic        r_neg;
    logic [31:0] r_mag;
    logic [5:0]  r_lz;
    logic        r_ov;

    logic        out_load;
    logic        s2_free;
    logic        s1_free;
    logic [31:0] sval;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] norm;
    logic [7:0]  expo;
    logic        up;
    logic [30:0] packed_em;
    logic [31:0] word;

    assign out_load = !r_ov || i_ready;
    assign s2_free  = !r_s2v || out_load;
    assign s1_free  = !r_s1v || s2_free;
    assign o_free   = s1_free;
    assign o_valid  = r_ov;

    // Sign and magnitude of a PCM sample.
    always_comb begin
        sval = (r_s1.mode == MODE_PCM16) ? {{16{r_s1.raw[15]}}, r_s1.raw[15:0]} : r_s1.raw;
        neg  = sval[31];
        mag  = neg ? 32'(-sval) : sval;
    end

    // Normalize, round to nearest even and pack.
    always_comb begin
        norm      = r_mag << r_lz;
        expo      = (r_s2.mode == MODE_PCM16) ? 8'(8'd143 - {2'b0, r_lz}) :
                                                8'(8'd127 - {2'b0, r_lz});
        up        = norm[7] && ((|norm[6:0]) || norm[8]);
        packed_em = 31'({expo, norm[30:8]} + {30'd0, up});
        if (!r_s2.valid)                word = 32'd0;
        else if (r_s2.mode == MODE_FLOAT) word = r_s2.raw;
        else if (r_mag == 32'd0)        word = 32'd0;
        else                            word = {r_neg, packed_em};
    end

    // Stage one: the result as produced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (s1_free) begin
            r_s1v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_valid) r_s1 <= i_res;
    end

    // Stage two: magnitude and leading-zero count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2v <= 1'b0;
        end else if (s2_free) begin
            r_s2v <= r_s1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1v) begin
            r_s2  <= r_s1;
            r_neg <= neg;
            r_mag <= mag;
            r_lz  <= lzc32(mag);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= r_s2v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s2v) begin
            o_sample_valid <= r_s2.valid;
            o_sample_word  <= word;
            o_sample_index <= r_s2.index;
            o_finished     <= r_s2.fin;
            o_status       <= r_s2.status;
            o_tap_count    <= r_s2.count;
        end
    end
endmodule

// File: tb/sv/wav_parser_scoreboard.sv
// Scoreboard for the WAV impulse-response parser: tracks the register port, predicts
// every result of the byte stream and compares it with the block's output beats.
// Depends on wipr_pkg for the status codes, chunk tags and register indexes.
`timescale 1ns / 1ps

module wav_parser_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_sample_valid,
    input  logic [31:0] i_sample_word,
    input  logic [12:0] i_sample_index,
    input  logic        i_finished,
    input  logic [2:0]  i_status,
    input  logic [13:0] i_tap_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    import wipr_pkg::*;

    typedef enum logic [2:0] {
        PH_HEAD, PH_CHDR, PH_FMT, PH_SKIP, PH_DATA, PH_HOLD, PH_DONE
    } t_phase;

    typedef struct {
        logic        sample_valid;
        logic [31:0] sample_word;
        logic [12:0] sample_index;
        logic        finished;
        logic [2:0]  status;
        logic [13:0] tap_count;
    } t_beat;

    localparam int TAP_LIMIT = DEF_MAX_TAPS;

    t_beat       expected_beats[$];
    t_beat       cur;
    logic [31:0] rate_reg;
    logic [13:0] taps_reg;

    t_phase      phase;
    logic [31:0] offset, tag, clen, fmt_code, chans, frate, bits, assembly;
    logic [31:0] emitted, target, byte_count, held;
    logic [63:0] skip_left;

    assign o_pending = expected_beats.size();

    // Integer to single precision with round to nearest even, then scaled by 2^-shift.
    function automatic logic [31:0] scaled_float(input logic signed [31:0] s, input int shift);
        logic [63:0] mag, m, rem, half;
        int          p, drop;
        logic [7:0]  ex;
        if (s == 0) return 32'd0;
        mag = s[31] ? (64'd0 - {{32{s[31]}}, s}) : {32'd0, s};
        p = 0;
        for (int i = 0; i < 33; i++) if (mag[i]) p = i;
        if (p <= 23) begin
            m = mag << (23 - p);
        end else begin
            drop = p - 23;
            m = mag >> drop;
            rem = mag & ((64'd1 << drop) - 1);
            half = 64'd1 << (drop - 1);
            if (rem > half || (rem == half && m[0])) m = m + 1;
            if (m[24]) begin
                m = m >> 1;
                p = p + 1;
            end
        end
        ex = 8'(p + 127 - shift);
        return {s[31], ex, m[22:0]};
    endfunction

    task automatic clear_parse();
        phase = PH_HEAD;
        offset = 0; tag = 0; clen = 0; fmt_code = 0; chans = 0; frate = 0; bits = 0;
        assembly = 0; emitted = 0; target = 0; byte_count = 0; skip_left = 0; held = 0;
    endtask

    task automatic conclude(input logic [2:0] st);
        cur.finished = 1'b1;
        cur.status = st;
        cur.tap_count = (st == ST_OK) ? target[13:0] : 14'd0;
        phase = PH_DONE;
    endtask

    // Errors before the minimum file length are held until that length is reached.
    task automatic report_error(input logic [2:0] st);
        if (byte_count >= MIN_FILE) conclude(st);
        else begin
            held = st;
            phase = PH_HOLD;
        end
    endtask

    task automatic start_skip(input logic [63:0] n);
        skip_left = n;
        offset = 0;
        phase = (n == 0) ? PH_CHDR : PH_SKIP;
    endtask

    task automatic open_chunk();
        logic [31:0] bps, n, cap;
        if (tag == TAG_FMT) begin
            if (clen < 16) report_error(ST_FORMAT);
            else begin
                offset = 0;
                phase = PH_FMT;
            end
        end else if (tag == TAG_DATA) begin
            if (chans != 1 || frate != rate_reg || (fmt_code != 1 && fmt_code != 3)) begin
                report_error(ST_FORMAT);
            end else begin
                bps = bits >> 3;
                if (bps == 0) report_error(ST_WIDTH);
                else begin
                    n = clen / bps;
                    cap = (taps_reg == 0) ? 1 : taps_reg;
                    if (cap > TAP_LIMIT) cap = TAP_LIMIT;
                    target = (n > cap) ? cap : n;
                    emitted = 0;
                    assembly = 0;
                    offset = 0;
                    phase = PH_DATA;
                    if (target == 0) conclude(ST_OK);
                end
            end
        end else begin
            start_skip({32'd0, clen} + clen[0]);
        end
    endtask

    task automatic take_sample_byte(input logic [7:0] b);
        logic [31:0] a, w, bps;
        bps = bits >> 3;
        if (offset < 4) assembly = assembly | ({24'd0, b} << (8 * offset));
        offset = offset + 1;
        if (offset >= bps) begin
            offset = 0;
            a = assembly;
            assembly = 0;
            if (fmt_code == 3 && bits == 32) w = a;
            else if (fmt_code == 1 && bits == 16) w = scaled_float({{16{a[15]}}, a[15:0]}, 15);
            else if (fmt_code == 1 && bits == 32) w = scaled_float(a, 31);
            else begin
                report_error(ST_WIDTH);
                return;
            end
            cur.sample_valid = 1'b1;
            cur.sample_word = w;
            cur.sample_index = emitted[12:0];
            emitted = emitted + 1;
            if (emitted >= target) conclude(ST_OK);
        end
    endtask

    // Advance the parse by one file byte and queue the result it causes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic eof);
        logic [31:0] off;
        logic [2:0]  st;
        cur = '{default: '0};
        if (byte_count < MIN_FILE) byte_count = byte_count + 1;
        off = offset;
        case (phase)
            PH_HEAD: begin
                if (off < 12 && (off < 4 || off >= 8) && b != head_byte(off[3:0])) begin
                    report_error(ST_HEADER);
                end else begin
                    offset = off + 1;
                    if (offset >= 12) begin
                        offset = 0;
                        phase = PH_CHDR;
                    end
                end
            end
            PH_CHDR: begin
                if (off == 0) tag = {24'd0, b};
                else if (off < 4) tag = tag | ({24'd0, b} << (8 * off));
                else if (off == 4) clen = {24'd0, b};
                else clen = clen | ({24'd0, b} << (8 * ((off - 4) & 3)));
                offset = off + 1;
                if (offset >= 8) begin
                    offset = 0;
                    open_chunk();
                end
            end
            PH_FMT: begin
                if (off == 0) fmt_code = {24'd0, b};
                else if (off == 1) fmt_code = fmt_code | ({24'd0, b} << 8);
                else if (off == 2) chans = {24'd0, b};
                else if (off == 3) chans = chans | ({24'd0, b} << 8);
                else if (off == 4) frate = {24'd0, b};
                else if (off < 8) frate = frate | ({24'd0, b} << (8 * ((off - 4) & 3)));
                else if (off == 14) bits = {24'd0, b};
                else if (off == 15) bits = bits | ({24'd0, b} << 8);
                offset = off + 1;
                if (offset >= 16) start_skip({32'd0, clen - 32'd16} + clen[0]);
            end
            PH_SKIP: begin
                if (skip_left > 0) skip_left = skip_left - 1;
                if (skip_left == 0) begin
                    offset = 0;
                    phase = PH_CHDR;
                end
            end
            PH_DATA: take_sample_byte(b);
            PH_HOLD: if (byte_count >= MIN_FILE) conclude(held[2:0]);
            default: ;
        endcase
        if (eof) begin
            if (!cur.finished && phase != PH_DONE) begin
                if (byte_count < MIN_FILE) st = ST_SHORT;
                else if (phase == PH_HOLD) st = held[2:0];
                else if (phase == PH_DATA) st = ST_OK;
                else st = ST_NODATA;
                conclude(st);
            end
            clear_parse();
        end
        if (cur.sample_valid || cur.finished) expected_beats.push_back(cur);
    endtask

    // Compare one output beat with the oldest expectation.
    task automatic compare_beat();
        t_beat exp_b;
        if (expected_beats.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: result beat with nothing expected (word %h fin %b)",
                         $realtime, i_sample_word, i_finished);
            return;
        end
        exp_b = expected_beats.pop_front();
        if (i_sample_valid !== exp_b.sample_valid || i_sample_word !== exp_b.sample_word ||
            i_sample_index !== exp_b.sample_index || i_finished !== exp_b.finished ||
            i_status !== exp_b.status || i_tap_count !== exp_b.tap_count) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: mismatch exp sv=%b w=%h idx=%0d fin=%b st=%0d cnt=%0d, got sv=%b w=%h idx=%0d fin=%b st=%0d cnt=%0d",
                         $realtime, exp_b.sample_valid, exp_b.sample_word,
                         exp_b.sample_index, exp_b.finished, exp_b.status, exp_b.tap_count,
                         i_sample_valid, i_sample_word, i_sample_index, i_finished,
                         i_status, i_tap_count);
        end
    endtask

    initial begin
        o_fail_count = 0;
        rate_reg = DEF_RATE;
        taps_reg = 14'(DEF_MAX_TAPS);
        clear_parse();
    end

    // Watch register writes and both channels at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_reg = DEF_RATE;
            taps_reg = 14'(DEF_MAX_TAPS);
            clear_parse();
            expected_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_RATE, 2'b00}) rate_reg = pwdata;
                else if (paddr == {REG_TAPS, 2'b00}) taps_reg = pwdata[13:0];
            end
            if (i_out_valid && i_out_ready) compare_beat();
            if (i_in_valid && i_in_ready) parse_byte(i_file_byte, i_end_of_file);
        end
    end

endmodule

// File: tb/sv/wav_impulse_response_parser_test.sv
// Top of the WAV impulse-response parser testbench: clock, reset, register writes,
// generated WAV files as byte stimulus, output stalls and the verdict.
// Depends on wipr_pkg, wav_impulse_response_parser and wav_parser_scoreboard.
`timescale 1ns / 1ps

module wav_impulse_response_parser_test;
    import wipr_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_file_byte;
    logic        i_end_of_file;
    logic        o_valid;
    logic        i_ready;
    logic        o_sample_valid;
    logic [31:0] o_sample_word;
    logic [12:0] o_sample_index;
    logic        o_finished;
    logic [2:0]  o_status;
    logic [13:0] o_tap_count;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    int          fail_count;
    int          pending;
    logic        quiet;
    logic        long_hold;
    logic [31:0] file_rate_now;
    logic [7:0]  file_bytes[$];
    logic [7:0]  sample_pattern[$];
    int          bytes_sent;

    wav_impulse_response_parser dut (.*);

    wav_parser_scoreboard scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_file_byte(i_file_byte), .i_end_of_file(i_end_of_file),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_sample_valid(o_sample_valid), .i_sample_word(o_sample_word),
        .i_sample_index(o_sample_index), .i_finished(o_finished),
        .i_status(o_status), .i_tap_count(o_tap_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // Output side: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        int n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
                i_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                n = $urandom_range(1, 15);
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Offer one byte and hold it until accepted; then possibly idle for a burst.
    task automatic offer_byte(input logic [7:0] b, input logic eof);
        int gap;
        i_valid <= 1'b1;
        i_file_byte <= b;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        bytes_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic stream_file();
        foreach (file_bytes[i]) offer_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    task automatic add16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endtask

    task automatic add32(input logic [31:0] v);
        add16(v[15:0]);
        add16(v[31:16]);
    endtask

    // Build a WAV file; data_sent bytes of the data chunk body are actually present.
    task automatic build_wav(input int fmt_len, input logic [15:0] code,
                             input logic [15:0] chans, input logic [31:0] rate,
                             input logic [15:0] bits, input logic [31:0] data_len,
                             input int data_sent, input int junk_len, input int trailer);
        add32(32'h46464952);
        add32($urandom);
        add32(32'h45564157);
        if (junk_len >= 0) begin
            add32(32'h4B4E554A);
            add32(junk_len);
            repeat (junk_len + (junk_len & 1)) file_bytes.push_back(8'($urandom));
        end
        add32(TAG_FMT);
        add32(fmt_len);
        add16(code); add16(chans); add32(rate); add32($urandom); add16(16'($urandom));
        add16(bits);
        repeat (fmt_len - 16 + (fmt_len & 1)) file_bytes.push_back(8'($urandom));
        add32(TAG_DATA);
        add32(data_len);
        for (int i = 0; i < data_sent; i++)
            file_bytes.push_back(i < sample_pattern.size() ? sample_pattern[i] : 8'($urandom));
        sample_pattern.delete();
        repeat (trailer) file_bytes.push_back(8'($urandom));
    endtask

    // One random file: mostly well formed with random content, some broken or noise.
    task automatic random_file();
        int kind, fl, dl, ds, pos;
        logic [15:0] code, chans, bits;
        logic [31:0] rate;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            repeat ($urandom_range(1, 60)) file_bytes.push_back(8'($urandom));
            stream_file();
            return;
        end
        fl = ($urandom_range(0, 9) < 8) ? 16 : $urandom_range(10, 19);
        code = ($urandom_range(0, 9) < 9) ? ($urandom_range(0, 1) ? 16'd1 : 16'd3) :
                                            16'($urandom);
        chans = ($urandom_range(0, 9) < 9) ? 16'd1 : 16'($urandom);
        rate = ($urandom_range(0, 9) < 9) ? file_rate_now : $urandom;
        case ($urandom_range(0, 11))
            0: bits = 16'd24;
            1: bits = 16'd8;
            2: bits = 16'($urandom_range(0, 7));
            3: bits = 16'($urandom);
            default: bits = $urandom_range(0, 1) ? 16'd16 : 16'd32;
        endcase
        dl = $urandom_range(0, 40);
        if ($urandom_range(0, 15) == 0) dl = 32'hFFFFFFF0 + $urandom_range(0, 15);
        ds = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) :
             ((dl > 40 || dl < 0) ? 40 : dl);
        build_wav(fl, code, chans, rate, bits, dl, ds,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1,
                  $urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
        case ($urandom_range(0, 11))
            0: file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
            1: begin
                pos = $urandom_range(0, 11);
                file_bytes[pos] = file_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
            end
            default: ;
        endcase
        stream_file();
    endtask

    // Wait for every result, then for the pipeline and the divider to settle.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] rates[8];
        logic [31:0] taps[8];
        int phase_goal;
        rates = '{32'd44100, 32'd0, 32'hFFFFFFFF, 32'd48000,
                  32'd96000, 32'd8000, 32'd22050, 32'd48000};
        taps = '{32'd1, 32'd16383, 32'd0, 32'd3, 32'd8192, 32'd5, 32'd2, 32'd8};
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_file_byte = '0; i_end_of_file = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        quiet = 1'b0; long_hold = 1'b0; bytes_sent = 0;
        file_rate_now = DEF_RATE;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed files: extreme samples, each format, header and length errors.
        sample_pattern = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00};
        build_wav(16, 16'd1, 16'd1, DEF_RATE, 16'd16, 6, 6, -1, 0);
        stream_file();
        sample_pattern = '{8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                           8'hC1, 8'hFF, 8'hFF, 8'h00};
        build_wav(16, 16'd1, 16'd1, DEF_RATE, 16'd32, 12, 12, 3, 2);
        stream_file();
        build_wav(18, 16'd3, 16'd1, DEF_RATE, 16'd32, 8, 8, -1, 0);
        stream_file();
        build_wav(16, 16'd1, 16'd1, DEF_RATE, 16'd16, 0, 0, -1, 3);
        stream_file();
        build_wav(16, 16'd1, 16'd1, DEF_RATE, 16'd24, 6, 6, -1, 0);
        stream_file();
        build_wav(16, 16'd1, 16'd1, DEF_RATE, 16'd4, 6, 6, -1, 0);
        stream_file();
        build_wav(12, 16'd1, 16'd1, DEF_RATE, 16'd16, 6, 6, -1, 0);
        stream_file();
        build_wav(16, 16'd1, 16'd2, DEF_RATE, 16'd16, 6, 6, -1, 0);
        stream_file();
        build_wav(16, 16'd1, 16'd1, DEF_RATE, 16'd16, 20, 5, -1, 0);
        stream_file();
        file_bytes = '{8'h52, 8'h49, 8'h46, 8'h58, 8'h00};
        stream_file();
        build_wav(16, 16'd1, 16'd1, DEF_RATE, 16'd16, 4, 0, -1, 0);
        file_bytes = file_bytes[0:35];
        stream_file();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 8; ph++) begin
            i_valid <= 1'b0;
            drain();
            reg_write(REG_RATE, rates[ph]);
            reg_write(REG_TAPS, taps[ph]);
            file_rate_now = rates[ph];
            if (ph == 2) long_hold = 1'b1;
            quiet = (ph == 7);
            phase_goal = bytes_sent + 90;
            while (bytes_sent < phase_goal) random_file();
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
